// ===== rtl/psk_pkg.sv =====
// Shared types, constants and lookup tables for the scancode translator.
package psk_pkg;

    // Scancode values with special meaning
    localparam logic [7:0] CODE_RELEASE = 8'hF0;
    localparam logic [7:0] CODE_EXTEND  = 8'hE0;
    localparam logic [7:0] CODE_SHIFT   = 8'h12;
    localparam logic [7:0] CODE_CTRL    = 8'h14;
    localparam logic [7:0] CODE_LEFT    = 8'h6B;
    localparam logic [7:0] CODE_RIGHT   = 8'h74;
    localparam logic [7:0] CODE_UP      = 8'h75;
    localparam logic [7:0] CODE_DOWN    = 8'h72;

    // Output characters
    localparam logic [7:0] CTRL_OFFSET  = 8'h60;
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_BRACKET   = 8'h5B;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;
    localparam logic [7:0] CH_UP        = 8'h41;
    localparam logic [7:0] CH_DOWN      = 8'h42;
    localparam logic [7:0] CH_RIGHT     = 8'h43;
    localparam logic [7:0] CH_LEFT      = 8'h44;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One translated key: one byte, or an escape sequence of three
    typedef struct packed {
        logic       three_bytes;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } job_t;

    // F-key table: [23:16] first byte after ESC, [15:8] second, [7:0] scancode
    localparam int NUM_FKEYS = 12;
    localparam logic [23:0] FKEY_TABLE [NUM_FKEYS] = '{
        24'h4F5005, 24'h4F5106, 24'h4F5204, 24'h4F530C,
        24'h313503, 24'h31370B, 24'h313883, 24'h31390A,
        24'h323001, 24'h323109, 24'h323378, 24'h323407
    };

    localparam logic [7:0] PLAIN_ROM [128] = '{
        8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
        8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h09, 8'h3F, 8'h3F,
        8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h71, 8'h31, 8'h3F,
        8'h3F, 8'h3F, 8'h7A, 8'h73, 8'h61, 8'h77, 8'h32, 8'h3F,
        8'h3F, 8'h63, 8'h78, 8'h64, 8'h65, 8'h34, 8'h33, 8'h3F,
        8'h3F, 8'h20, 8'h76, 8'h66, 8'h74, 8'h72, 8'h35, 8'h3F,
        8'h3F, 8'h6E, 8'h62, 8'h68, 8'h67, 8'h79, 8'h36, 8'h3F,
        8'h3F, 8'h3F, 8'h6D, 8'h6A, 8'h75, 8'h37, 8'h38, 8'h3F,
        8'h2C, 8'h3F, 8'h6B, 8'h69, 8'h6F, 8'h30, 8'h39, 8'h3F,
        8'h3F, 8'h2E, 8'h2F, 8'h6C, 8'h3B, 8'h70, 8'h2D, 8'h3F,
        8'h3F, 8'h3F, 8'h20, 8'h3F, 8'h5B, 8'h3D, 8'h08, 8'h3F,
        8'h3F, 8'h3F, 8'h0D, 8'h5D, 8'h3F, 8'h5C, 8'h3F, 8'h3F,
        8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h1B, 8'h3F,
        8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
        8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
        8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F
    };

    localparam logic [7:0] SHIFTED_ROM [128] = '{
        8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
        8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h09, 8'h3F, 8'h3F,
        8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h51, 8'h21, 8'h3F,
        8'h3F, 8'h3F, 8'h5A, 8'h53, 8'h41, 8'h57, 8'h40, 8'h3F,
        8'h3F, 8'h43, 8'h58, 8'h44, 8'h45, 8'h24, 8'h23, 8'h3F,
        8'h3F, 8'h20, 8'h56, 8'h46, 8'h54, 8'h52, 8'h25, 8'h3F,
        8'h3F, 8'h4E, 8'h42, 8'h48, 8'h47, 8'h59, 8'h5E, 8'h3F,
        8'h3F, 8'h3F, 8'h4D, 8'h4A, 8'h55, 8'h26, 8'h2A, 8'h3F,
        8'h3C, 8'h3F, 8'h4B, 8'h49, 8'h4F, 8'h29, 8'h28, 8'h3F,
        8'h3E, 8'h3E, 8'h3F, 8'h4C, 8'h3A, 8'h50, 8'h5F, 8'h3F,
        8'h3F, 8'h3F, 8'h20, 8'h3F, 8'h7B, 8'h2B, 8'h08, 8'h3F,
        8'h3F, 8'h3F, 8'h0D, 8'h7D, 8'h3F, 8'h5C, 8'h3F, 8'h3F,
        8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h1B, 8'h3F,
        8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
        8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
        8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F
    };

endpackage

// ===== rtl/psk_front.sv =====
// Front end: accepts scancodes, tracks modifiers and builds translation requests.
module psk_front import psk_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] scan_code,
    input  logic       q_full,
    output logic       push,
    output job_t       push_job
);

    logic [7:0] prev_reg, prev_next;
    logic       shift_reg, shift_next;
    logic       ctrl_reg, ctrl_next;
    logic       accept;
    logic       emit;
    logic       fkey_hit;
    logic [7:0] fkey_b1, fkey_b2;
    logic [7:0] plain_b, shifted_b;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept && emit;

    // F-key match: twelve independent compares
    always_comb
    begin
        fkey_hit = 1'b0;
        fkey_b1  = 8'h00;
        fkey_b2  = 8'h00;
        for (int m = 0; m < NUM_FKEYS; m++)
        begin
            if (FKEY_TABLE[m][7:0] == scan_code && !fkey_hit)
            begin
                fkey_hit = 1'b1;
                fkey_b1  = FKEY_TABLE[m][23:16];
                fkey_b2  = FKEY_TABLE[m][15:8];
            end
        end
    end

    assign plain_b   = PLAIN_ROM[scan_code[6:0]];
    assign shifted_b = SHIFTED_ROM[scan_code[6:0]];

    // Classify the code and update the modifier flags
    always_comb
    begin
        shift_next           = shift_reg;
        ctrl_next            = ctrl_reg;
        emit                 = 1'b0;
        push_job.three_bytes = 1'b0;
        push_job.b0          = CH_QUESTION;
        push_job.b1          = CH_BRACKET;
        push_job.b2          = CH_QUESTION;
        if (prev_reg == CODE_RELEASE)
        begin
            if (scan_code == CODE_SHIFT)
                shift_next = 1'b0;
            else if (scan_code == CODE_CTRL)
                ctrl_next = 1'b0;
        end
        else if (scan_code != CODE_RELEASE && scan_code != CODE_EXTEND)
        begin
            if (fkey_hit)
            begin
                emit                 = 1'b1;
                push_job.three_bytes = 1'b1;
                push_job.b0          = CH_ESC;
                push_job.b1          = fkey_b1;
                push_job.b2          = fkey_b2;
            end
            else if (scan_code == CODE_SHIFT)
                shift_next = 1'b1;
            else if (scan_code == CODE_CTRL)
                ctrl_next = 1'b1;
            else if (scan_code == CODE_LEFT || scan_code == CODE_RIGHT ||
                     scan_code == CODE_UP || scan_code == CODE_DOWN)
            begin
                emit                 = 1'b1;
                push_job.three_bytes = 1'b1;
                push_job.b0          = CH_ESC;
                push_job.b1          = CH_BRACKET;
                if (scan_code == CODE_LEFT)
                    push_job.b2 = CH_LEFT;
                else if (scan_code == CODE_RIGHT)
                    push_job.b2 = CH_RIGHT;
                else if (scan_code == CODE_UP)
                    push_job.b2 = CH_UP;
                else
                    push_job.b2 = CH_DOWN;
            end
            else
            begin
                emit = 1'b1;
                if (scan_code[7])
                    push_job.b0 = CH_QUESTION;
                else if (shift_reg)
                    push_job.b0 = shifted_b;
                else if (ctrl_reg)
                    push_job.b0 = (plain_b > CTRL_OFFSET) ? (plain_b - CTRL_OFFSET) : 8'h00;
                else
                    push_job.b0 = plain_b;
            end
        end
    end

    assign prev_next = scan_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 8'h00;
            shift_reg <= 1'b0;
            ctrl_reg  <= 1'b0;
        end
        else if (accept)
        begin
            prev_reg  <= prev_next;
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
        end
    end

endmodule

// ===== rtl/psk_queue.sv =====
// Short request queue between the front end and the byte sequencer.
module psk_queue import psk_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t head
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== rtl/psk_back.sv =====
// Back end: walks each queued request into the output register, one byte per cycle unless stalled.
module psk_back import psk_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  job_t       q_head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] key_byte,
    output logic       last_byte
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] key_byte_reg, key_byte_next;
    logic       last_byte_reg, last_byte_next;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       is_last;
    logic [7:0] sel_byte;

    assign load = !out_valid_reg || !out_stall;

    // Byte of the head request at the current position
    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = q_head.b0;
            2'd1:    sel_byte = q_head.b1;
            default: sel_byte = q_head.b2;
        endcase
    end

    assign is_last = !q_head.three_bytes || (idx_reg == 2'd2);
    assign pop     = load && !q_empty && is_last;

    // Output register load and position advance
    always_comb
    begin
        out_valid_next = out_valid_reg;
        key_byte_next  = key_byte_reg;
        last_byte_next = last_byte_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = !q_empty;
            if (!q_empty)
            begin
                key_byte_next  = sel_byte;
                last_byte_next = is_last;
                idx_next       = is_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_byte_reg  <= key_byte_next;
        last_byte_reg <= last_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign key_byte  = key_byte_reg;
    assign last_byte = last_byte_reg;

endmodule

// ===== rtl/ps2_scancode_to_terminal_keys.sv =====
// PS/2 set-2 scancode to terminal byte translator, top level.
//
// Input channel: in_valid / in_stall / scan_code, one scancode byte per request.
// Output channel: out_valid / out_stall / key_byte / last_byte, one terminal
// byte per request; last_byte marks the final byte of a scancode's sequence.
// Break prefixes, releases, extended prefixes and modifier presses produce
// no output bytes; F-keys and arrows produce three bytes (ESC sequence);
// any other key produces one byte.
// With the queue empty, an accepted scancode's request is written into the
// queue, then its first byte is loaded into the output register that drives
// key_byte. The front end takes one scancode per cycle while the 4-entry
// request queue has room; the back end sends one byte per cycle while
// out_stall is low, so an escape-sequence key holds the single output port
// for three bytes and any other key for one.
// in_stall rises only when the queue is full.
// Reset clears the previous-code and shift/ctrl state, empties the queue
// and drops out_valid. While out_stall is high the output register holds
// its byte; the queue keeps absorbing scancodes until it fills.
module ps2_scancode_to_terminal_keys import psk_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] scan_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] key_byte,
    output logic       last_byte
);

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    job_t push_job;
    job_t q_head;

    psk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .scan_code (scan_code),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    psk_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    psk_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_byte  (key_byte),
        .last_byte (last_byte)
    );

endmodule
